[rtl/hbp_pkg.sv]
package hbp_pkg;

  // Input operation codes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  // Result status codes
  localparam logic STAT_DATA   = 1'b0;
  localparam logic STAT_NOCODE = 1'b1;

  // Width of a stored code length (0 to 32)
  localparam int unsigned LEN_W = 6;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  symbol;
    logic [31:0] code_bits;
    logic [5:0]  code_length;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       status;
    logic       last_of_run;
  } out_t;

endpackage

[rtl/hbp_ram.sv]
module hbp_ram #(
  parameter int unsigned WIDTH = 38,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

[rtl/huffman_table_bit_packer.sv]
// Huffman table bit packer. Load beats write one code table entry (code bits
// plus length, length zero marks the symbol uncoded); encode beats look up a
// symbol and pack its code LSB-first behind up to 7 pending bits, giving one
// result beat per completed byte with last_of_run on the final one; flush
// beats emit the pending bits zero-padded in a byte. An uncoded or
// out-of-range symbol gives a single result with status 1 and out_byte 0.
// One item is in work at a time: a load, a flush with pending bits, or an
// encode that reads the table RAM (registered) and then gives up to 4
// bytes from the single output register, one byte per cycle while out_ready
// is high. The table clears at reset through one valid flip-flop per
// entry, so no clearing pass is needed.
module huffman_table_bit_packer #(
  parameter int unsigned SYMBOL_COUNT = 256,
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hbp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output hbp_pkg::out_t out_data
);

  // Longest code kept in the table; longer loads saturate to it
  localparam int unsigned CODE_W = (MAX_CODE_LEN > 32) ? 32 : MAX_CODE_LEN;
  localparam int unsigned IDX_W  = $clog2(SYMBOL_COUNT);
  localparam int unsigned ENT_W  = CODE_W + hbp_pkg::LEN_W;
  localparam int unsigned ACC_W  = 39;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  function automatic logic [31:0] len_mask(logic [5:0] len);
    logic [31:0] m;
    for (int i = 0; i < 32; i++) begin
      m[i] = (6'(i) < len);
    end
    return m;
  endfunction

  logic [1:0]              state_r, state_nxt;
  logic [SYMBOL_COUNT-1:0] valid_r, valid_nxt;
  logic                    hit_r, hit_nxt;
  logic [6:0]              pend_bits_r, pend_bits_nxt;
  logic [2:0]              pend_cnt_r, pend_cnt_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [2:0]              rem_r, rem_nxt;
  logic                    out_valid_r, out_valid_nxt;
  hbp_pkg::out_t           out_r, out_nxt;

  logic                    in_acc;
  logic                    out_acc;
  logic                    in_range;
  logic [IDX_W-1:0]        idx;
  logic [5:0]              load_len;
  logic                    ram_we;
  logic                    ram_re;
  logic [ENT_W-1:0]        ram_wdata;
  logic [ENT_W-1:0]        ram_rdata;

  // Lookup datapath
  logic [5:0]              look_len;
  logic [31:0]             look_code;
  logic [ACC_W-1:0]        look_acc;
  logic [5:0]              look_total;
  logic [2:0]              look_nbytes;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_acc   = out_valid_r && out_ready;

  assign in_range = ({1'b0, in_data.symbol} < 9'(SYMBOL_COUNT));
  assign idx      = in_data.symbol[IDX_W-1:0];

  // Saturate overlong lengths on load
  assign load_len = (in_data.code_length > 6'(CODE_W)) ? 6'(CODE_W) : in_data.code_length;

  assign ram_we    = in_acc && (in_data.opcode == hbp_pkg::OP_LOAD) && in_range;
  assign ram_re    = in_acc && (in_data.opcode == hbp_pkg::OP_ENCODE);
  assign ram_wdata = {in_data.code_bits[CODE_W-1:0], load_len};

  hbp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // An entry never loaded since reset reads as length zero
  assign look_len    = hit_r ? ram_rdata[hbp_pkg::LEN_W-1:0] : 6'd0;
  assign look_code   = 32'(ram_rdata[ENT_W-1:hbp_pkg::LEN_W]) & len_mask(look_len);
  assign look_acc    = ACC_W'(pend_bits_r) | (ACC_W'(look_code) << pend_cnt_r);
  assign look_total  = 6'(pend_cnt_r) + look_len;
  assign look_nbytes = look_total[5:3];

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    hit_nxt       = hit_r;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.opcode)
            hbp_pkg::OP_LOAD: begin
              if (in_range) begin
                valid_nxt[idx] = 1'b1;
              end
            end
            hbp_pkg::OP_ENCODE: begin
              // Capture entry validity alongside the RAM read
              hit_nxt   = in_range && valid_r[idx];
              state_nxt = ST_LOOK;
            end
            hbp_pkg::OP_FLUSH: begin
              if (pend_cnt_r != 3'd0) begin
                out_nxt.out_byte    = {1'b0, pend_bits_r};
                out_nxt.status      = hbp_pkg::STAT_DATA;
                out_nxt.last_of_run = 1'b1;
                out_valid_nxt       = 1'b1;
                acc_nxt             = '0;
                rem_nxt             = 3'd0;
                pend_cnt_nxt        = 3'd0;
                state_nxt           = ST_EMIT;
              end
            end
            default: begin
              // drop unused opcode
            end
          endcase
        end
      end

      ST_LOOK: begin
        if (look_len == 6'd0) begin
          // Uncoded symbol: error beat, keep pending bits as they are
          out_nxt.out_byte    = 8'd0;
          out_nxt.status      = hbp_pkg::STAT_NOCODE;
          out_nxt.last_of_run = 1'b1;
          out_valid_nxt       = 1'b1;
          acc_nxt             = ACC_W'(pend_bits_r);
          rem_nxt             = 3'd0;
          state_nxt           = ST_EMIT;
        end else begin
          pend_cnt_nxt = look_total[2:0];
          if (look_nbytes == 3'd0) begin
            pend_bits_nxt = look_acc[6:0];
            state_nxt     = ST_IDLE;
          end else begin
            out_nxt.out_byte    = look_acc[7:0];
            out_nxt.status      = hbp_pkg::STAT_DATA;
            out_nxt.last_of_run = (look_nbytes == 3'd1);
            out_valid_nxt       = 1'b1;
            acc_nxt             = look_acc >> 8;
            rem_nxt             = look_nbytes - 3'd1;
            state_nxt           = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (out_acc) begin
          if (rem_r == 3'd0) begin
            // Final beat taken: leftover bits become the pending bits
            pend_bits_nxt = acc_r[6:0];
            out_valid_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            // Advance to the next completed byte
            out_nxt.out_byte    = acc_r[7:0];
            out_nxt.status      = hbp_pkg::STAT_DATA;
            out_nxt.last_of_run = (rem_r == 3'd1);
            acc_nxt             = acc_r >> 8;
            rem_nxt             = rem_r - 3'd1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      hit_r       <= 1'b0;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      hit_r       <= hit_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    out_r <= out_nxt;
  end

  // Input side and result side never active together
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result beat is pending");

  // Error beats carry a zero byte and close the run
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == hbp_pkg::STAT_NOCODE)
      |-> (out_data.out_byte == 8'd0 && out_data.last_of_run))
    else $error("malformed error beat");

  // Flush clears the pending count
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.opcode == hbp_pkg::OP_FLUSH) |=> (pend_cnt_r == 3'd0))
    else $error("pending count not cleared by flush");

  // Encode goes to table lookup on the next cycle
  a_encode_look: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.opcode == hbp_pkg::OP_ENCODE) |=> (state_r == ST_LOOK))
    else $error("encode did not enter lookup");

endmodule
